// ----- src/ws2812_pixel_serializer_defines.svh -----
// Assertion helpers used by the serializer back end.
`ifndef WS2812_PIXEL_SERIALIZER_DEFINES_SVH
`define WS2812_PIXEL_SERIALIZER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define WPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wps_pkg.sv -----
package wps_pkg;

    // Number of colour bits in one pixel word
    localparam int COLOR_BITS = 24;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 2;

    // Tick register defaults
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd40;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd22;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd20;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd42;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 2'd0,
        CFG_ONE_LOW   = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_ZERO_LOW  = 2'd3
    } cfg_index_t;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        logic                  is_load;
        logic [COLOR_BITS-1:0] grb;
    } cmd_t;

    // A zero tick count behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

// ----- src/wps_in_if.sv -----
interface wps_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output mode, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input mode, input red, input green, input blue,
                  output ready);
endinterface

// ----- src/wps_out_if.sv -----
interface wps_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic load_dropped;
    logic pixel_done;

    modport source (output valid, output line_level, output busy_res,
                    output load_dropped, output pixel_done, input ready);
    modport sink (input valid, input line_level, input busy_res,
                  input load_dropped, input pixel_done, output ready);
endinterface

// ----- src/wps_cfg_if.sv -----
interface wps_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/wps_front.sv -----
module wps_front (
    wps_in_if.sink          pixel_in,
    output logic            push_valid,
    input  logic            push_ready,
    output wps_pkg::cmd_t   push_cmd
);

    // Take a word whenever the queue has room
    assign pixel_in.ready = push_ready;
    assign push_valid     = pixel_in.valid;

    // Decode the mode and pack the colour bytes in send order
    always_comb
    begin
        push_cmd.is_load = (wps_pkg::mode_t'(pixel_in.mode) == wps_pkg::MODE_LOAD);
        push_cmd.grb     = {pixel_in.green, pixel_in.red, pixel_in.blue};
    end

endmodule

// ----- src/wps_queue.sv -----
module wps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  wps_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output wps_pkg::cmd_t   pop_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wps_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/wps_back.sv -----
`include "ws2812_pixel_serializer_defines.svh"

module wps_back #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  wps_pkg::cmd_t   pop_cmd,
    wps_cfg_if.sink         cfg,
    wps_out_if.source       result_out
);

    localparam int BL_W = $clog2(BITS_PER_PIXEL + 1);
    localparam int TW   = wps_pkg::TICK_W;

    // Tick registers
    logic [TW-1:0] one_high_reg;
    logic [TW-1:0] one_low_reg;
    logic [TW-1:0] zero_high_reg;
    logic [TW-1:0] zero_low_reg;

    // Waveform state
    logic [BITS_PER_PIXEL-1:0] shift_reg;
    logic [BITS_PER_PIXEL-1:0] shift_next;
    logic [BL_W-1:0]           bits_left_reg;
    logic [BL_W-1:0]           bits_left_next;
    logic [BL_W-1:0]           bits_dec;
    logic                      high_reg;
    logic                      high_next;
    logic [TW-1:0]             count_reg;
    logic [TW-1:0]             count_next;
    logic [TW-1:0]             count_dec;
    logic                      sending_reg;
    logic                      sending_next;
    logic                      dropped;
    logic                      done;
    logic                      take;
    logic [BITS_PER_PIXEL-1:0] load_word;

    // Result register
    logic out_valid_reg;
    logic line_level_reg;
    logic busy_res_reg;
    logic load_dropped_reg;
    logic pixel_done_reg;

    assign pop_ready = !out_valid_reg || result_out.ready;
    assign take      = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;

    assign load_word = BITS_PER_PIXEL'(pop_cmd.grb) << (BITS_PER_PIXEL - wps_pkg::COLOR_BITS);
    assign count_dec = (count_reg != '0) ? TW'(count_reg - 1'b1) : '0;
    assign bits_dec  = (bits_left_reg != '0) ? BL_W'(bits_left_reg - 1'b1) : '0;

    // Apply one command to the waveform state
    always_comb
    begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        high_next      = high_reg;
        count_next     = count_reg;
        sending_next   = sending_reg;
        dropped        = 1'b0;
        done           = 1'b0;
        if (take)
        begin
            if (pop_cmd.is_load)
            begin
                if (sending_reg)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    shift_next     = load_word;
                    bits_left_next = BL_W'(BITS_PER_PIXEL);
                    sending_next   = 1'b1;
                    high_next      = 1'b1;
                    count_next     = wps_pkg::at_least_one(
                        pop_cmd.grb[wps_pkg::COLOR_BITS-1] ? one_high_reg : zero_high_reg);
                end
            end
            else if (sending_reg)
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    if (high_reg)
                    begin
                        high_next  = 1'b0;
                        count_next = wps_pkg::at_least_one(
                            shift_reg[BITS_PER_PIXEL-1] ? one_low_reg : zero_low_reg);
                    end
                    else
                    begin
                        shift_next     = shift_reg << 1;
                        bits_left_next = bits_dec;
                        if (bits_dec == '0)
                        begin
                            sending_next = 1'b0;
                            high_next    = 1'b0;
                            count_next   = '0;
                            done         = 1'b1;
                        end
                        else
                        begin
                            high_next  = 1'b1;
                            count_next = wps_pkg::at_least_one(
                                shift_reg[BITS_PER_PIXEL-2] ? one_high_reg : zero_high_reg);
                        end
                    end
                end
            end
        end
    end

    // Hold the waveform state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
            high_reg      <= 1'b0;
            count_reg     <= '0;
            sending_reg   <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            sending_reg   <= sending_next;
        end
    end

    // Write tick registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= wps_pkg::ONE_HIGH_RST;
            one_low_reg   <= wps_pkg::ONE_LOW_RST;
            zero_high_reg <= wps_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= wps_pkg::ZERO_LOW_RST;
        end
        else if (cfg.valid)
        begin
            case (wps_pkg::cfg_index_t'(cfg.index))
                wps_pkg::CFG_ONE_HIGH:  one_high_reg  <= cfg.data;
                wps_pkg::CFG_ONE_LOW:   one_low_reg   <= cfg.data;
                wps_pkg::CFG_ZERO_HIGH: zero_high_reg <= cfg.data;
                wps_pkg::CFG_ZERO_LOW:  zero_low_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            line_level_reg   <= sending_next && high_next;
            busy_res_reg     <= sending_next;
            load_dropped_reg <= dropped;
            pixel_done_reg   <= done;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.line_level   = line_level_reg;
    assign result_out.busy_res     = busy_res_reg;
    assign result_out.load_dropped = load_dropped_reg;
    assign result_out.pixel_done   = pixel_done_reg;

    `WPS_ASSERT_IMP(a_high_only_sending, clk, rst_n, high_reg, sending_reg, "high phase while idle")
    `WPS_ASSERT_IMP(a_idle_clear, clk, rst_n, !sending_reg, (bits_left_reg == '0) && (count_reg == '0), "idle state not clear")
    `WPS_ASSERT_IMP(a_count_live, clk, rst_n, sending_reg, (count_reg != '0) && (bits_left_reg != '0), "phase or bit count empty while sending")
    `WPS_ASSERT_NEXT(a_load_starts, clk, rst_n, take && pop_cmd.is_load && !sending_reg, sending_reg && high_reg, "accepted load did not start high phase")

endmodule

// ----- src/ws2812_pixel_serializer.sv -----
// Single-wire WS2812 serializer. A load word (mode 0) starts a pixel if the
// block is idle, otherwise it is dropped and flagged; tick words (mode 1) step
// the waveform. Bits go out green, red, blue, MSB first, each a high pulse then
// a low pulse whose tick counts come from the four config registers (zero acts
// as one). Every input word yields exactly one result word. The block takes one
// word per clock while results are being taken; each word passes through the
// two-entry command queue and then the registered state update in the back
// end before its result appears. Config writes are taken at any time but are
// meant for idle periods.
module ws2812_pixel_serializer #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    wps_in_if.sink    pixel_in,
    wps_cfg_if.sink   cfg,
    wps_out_if.source result_out
);

    logic          push_valid;
    logic          push_ready;
    wps_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    wps_pkg::cmd_t pop_cmd;

    wps_front u_front (
        .pixel_in   (pixel_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    wps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    wps_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .cfg        (cfg),
        .result_out (result_out)
    );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int PIXEL_BITS      = wps_pkg::COLOR_BITS;
    localparam int TICK_W          = wps_pkg::TICK_W;
    localparam int RESULT_LATENCY  = 2;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 3;
    localparam int WORDS_PER_PHASE = 40;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_dropped;
        logic pixel_done;
    } wire_state_t;

    logic clk = 1'b0;
    logic rst_n;

    wps_in_if  pix_ch();
    wps_cfg_if cfg_ch();
    wps_out_if res_ch();

    ws2812_pixel_serializer #(
        .BITS_PER_PIXEL(PIXEL_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_ch),
        .cfg       (cfg_ch),
        .result_out(res_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Waveform state as the block should hold it
    logic [TICK_W-1:0]     tick_regs [wps_pkg::cfg_index_t];
    logic [PIXEL_BITS-1:0] pend_bits;
    int unsigned           bits_to_go;
    logic                  high_phase;
    logic [TICK_W-1:0]     phase_ticks;
    logic                  pixel_active;

    wire_state_t expected_q[$];

    bit          tx_jitter = 1'b1;
    bit          rx_jitter = 1'b1;
    int unsigned hold_request = 0;

    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned pixels_started = 0;
    int unsigned results_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned done_seen = 0;

    // Zero-length phases stretch to a single tick
    function automatic logic [TICK_W-1:0] tick_floor(input logic [TICK_W-1:0] v);
        return v | TICK_W'(v == '0);
    endfunction

    function automatic void begin_high_pulse();
        high_phase  = 1'b1;
        phase_ticks = tick_floor(pend_bits[PIXEL_BITS-1] ? tick_regs[wps_pkg::CFG_ONE_HIGH]
                                                         : tick_regs[wps_pkg::CFG_ZERO_HIGH]);
    endfunction

    // Advance the expected waveform by one input word
    function automatic wire_state_t step_waveform(input wps_pkg::mode_t m,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        wire_state_t res;
        res = '0;
        if (m == wps_pkg::MODE_LOAD) begin
            if (pixel_active) begin
                res.load_dropped = 1'b1;
            end
            else begin
                pend_bits = '0;
                pend_bits[PIXEL_BITS-1 -: wps_pkg::COLOR_BITS] = {g, r, b};
                bits_to_go   = PIXEL_BITS;
                pixel_active = 1'b1;
                pixels_started++;
                begin_high_pulse();
            end
        end
        else if (pixel_active) begin
            if (phase_ticks != '0)
                phase_ticks = phase_ticks - 1'b1;
            if (phase_ticks == '0) begin
                if (high_phase) begin
                    high_phase  = 1'b0;
                    phase_ticks = tick_floor(pend_bits[PIXEL_BITS-1]
                                             ? tick_regs[wps_pkg::CFG_ONE_LOW]
                                             : tick_regs[wps_pkg::CFG_ZERO_LOW]);
                end
                else begin
                    pend_bits = pend_bits << 1;
                    if (bits_to_go != 0)
                        bits_to_go--;
                    if (bits_to_go == 0) begin
                        pixel_active   = 1'b0;
                        high_phase     = 1'b0;
                        phase_ticks    = '0;
                        res.pixel_done = 1'b1;
                    end
                    else begin
                        begin_high_pulse();
                    end
                end
            end
        end
        res.line_level = pixel_active && high_phase;
        res.busy_res   = pixel_active;
        return res;
    endfunction

    // Offer one word; valid stays high on return, caller drops it when idling
    task automatic send_word(input wps_pkg::mode_t m, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        pix_ch.valid <= 1'b1;
        pix_ch.mode  <= m;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        do @(posedge clk); while (!pix_ch.ready);
        expected_q.push_back(step_waveform(m, r, g, b));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_word(wps_pkg::MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Insert a random idle burst on the input side
    task automatic sender_gap();
        if (tx_jitter && $urandom_range(0, 9) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic tick_run(input int unsigned n);
        repeat (n) begin
            sender_gap();
            send_tick();
        end
    endtask

    task automatic finish_pixel();
        while (pixel_active) begin
            sender_gap();
            send_tick();
        end
    endtask

    // Hold the input until every expected word has come back
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        do @(negedge clk); while (expected_q.size() != 0);
    endtask

    task automatic put_reg(input wps_pkg::cfg_index_t idx, input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        tick_regs[idx] = v;
        @(negedge clk);
    endtask

    task automatic write_timing(input logic [7:0] oh, input logic [7:0] ol,
                                input logic [7:0] zh, input logic [7:0] zl);
        wait_drained();
        put_reg(wps_pkg::CFG_ONE_HIGH, oh);
        put_reg(wps_pkg::CFG_ONE_LOW, ol);
        put_reg(wps_pkg::CFG_ZERO_HIGH, zh);
        put_reg(wps_pkg::CFG_ZERO_LOW, zl);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_ticks();
        case ($urandom_range(0, 15))
            0:       return 8'd0;
            1:       return 8'($urandom_range(5, 255));
            default: return 8'($urandom_range(1, 4));
        endcase
    endfunction

    // Ticks with nothing loaded leave the line low
    task automatic test_idle_ticks();
        tick_run(3);
    endtask

    // Reset timing over a one bit and a zero bit, a dropped load, then zero registers
    task automatic test_reset_timing();
        send_word(wps_pkg::MODE_LOAD, 8'h3C, 8'hA5, 8'h81);
        tick_run(130);
        send_word(wps_pkg::MODE_LOAD, 8'hFF, 8'hFF, 8'hFF);
        write_timing(8'd0, 8'd0, 8'd0, 8'd0);
        finish_pixel();
    endtask

    // Load one tick before the end is dropped; load right after the end is taken
    task automatic test_pixel_boundary();
        write_timing(8'd1, 8'd1, 8'd1, 8'd1);
        send_word(wps_pkg::MODE_LOAD, 8'hFF, 8'hFF, 8'hFF);
        while (!(bits_to_go == 1 && !high_phase && phase_ticks == 1))
            send_tick();
        send_word(wps_pkg::MODE_LOAD, 8'h00, 8'h00, 8'h00);
        send_tick();
        send_word(wps_pkg::MODE_LOAD, 8'h00, 8'h00, 8'h00);
        finish_pixel();
    endtask

    // Longest high pulse on a leading one bit, longest low pulse on the zero bit after it,
    // then short timing for the rest of the pixel
    task automatic test_pulse_extremes();
        write_timing(8'd255, 8'd1, 8'd1, 8'd255);
        send_word(wps_pkg::MODE_LOAD, 8'h00, 8'h80, 8'h00);
        while (bits_to_go == PIXEL_BITS || high_phase)
            send_tick();
        write_timing(8'd1, 8'd1, 8'd1, 8'd1);
        finish_pixel();
    endtask

    // Stall the output long enough to fill the block, then pause the input
    task automatic test_backpressure();
        write_timing(8'd2, 8'd3, 8'd1, 8'd2);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        hold_request = HOLD_CYCLES;
        wait (res_ch.ready == 1'b0);
        @(negedge clk);
        send_word(wps_pkg::MODE_LOAD, 8'h5A, 8'hC3, 8'h96);
        repeat (40) send_tick();
        wait_drained();
        tick_run(20);
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    // Mostly pixels with random content and timing, some loads into a busy block
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end
            write_timing(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                sender_gap();
                if ($urandom_range(0, pixel_active ? 19 : 1) == 0)
                    send_word(wps_pkg::MODE_LOAD, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    send_tick();
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int unsigned burst;
        res_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            burst = 0;
            if (hold_request != 0) begin
                burst = hold_request;
                hold_request = 0;
            end
            else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18);
            end
            if (burst != 0) begin
                res_ch.ready <= 1'b0;
                repeat (burst) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    function automatic void compare_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s expected %b got %b", $time, name, want, got);
            errors++;
        end
    endfunction

    // Check each result word against the oldest expectation
    always @(posedge clk) begin
        wire_state_t got;
        wire_state_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.line_level, res_ch.busy_res, res_ch.load_dropped, res_ch.pixel_done};
            results_seen++;
            if (got.load_dropped === 1'b1)
                drops_seen++;
            if (got.pixel_done === 1'b1)
                done_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: result word %b with nothing expected", $time, got);
                errors++;
            end
            else begin
                want = expected_q.pop_front();
                compare_bit("line_level", want.line_level, got.line_level);
                compare_bit("busy_res", want.busy_res, got.busy_res);
                compare_bit("load_dropped", want.load_dropped, got.load_dropped);
                compare_bit("pixel_done", want.pixel_done, got.pixel_done);
            end
        end
    end

    // End the run when no channel moves a word for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.mode  = wps_pkg::MODE_TICK;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = wps_pkg::CFG_ONE_HIGH;
        cfg_ch.data  = '0;

        tick_regs[wps_pkg::CFG_ONE_HIGH]  = wps_pkg::ONE_HIGH_RST;
        tick_regs[wps_pkg::CFG_ONE_LOW]   = wps_pkg::ONE_LOW_RST;
        tick_regs[wps_pkg::CFG_ZERO_HIGH] = wps_pkg::ZERO_HIGH_RST;
        tick_regs[wps_pkg::CFG_ZERO_LOW]  = wps_pkg::ZERO_LOW_RST;
        pend_bits    = '0;
        bits_to_go   = 0;
        high_phase   = 1'b0;
        phase_ticks  = '0;
        pixel_active = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_reset_timing();
        test_pixel_boundary();
        test_pulse_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (RESULT_LATENCY + 4) @(negedge clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, expected_q.size());
            errors++;
        end

        $display("sent %0d input words: %0d pixels started, %0d loads dropped",
                 words_sent, pixels_started, drops_seen);
        $display("checked %0d result words, %0d pixel ends, %0d mismatches",
                 results_seen, done_seen, errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
